// File: hdl/wsfd_pkg.sv
// shared types and constants of the websocket frame deframer
package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_KEY,
        PH_DATA
    } wsfd_phase_t;

    localparam logic [2:0]  KIND_MSG    = 3'd0;
    localparam logic [2:0]  KIND_EMPTY  = 3'd1;
    localparam logic [2:0]  KIND_CLOSE  = 3'd2;
    localparam logic [2:0]  KIND_REASON = 3'd3;
    localparam logic [2:0]  KIND_ERROR  = 3'd4;

    localparam logic [3:0]  OPC_CLOSE   = 4'h8;
    localparam logic [15:0] CODE_NORMAL = 16'd1000;
    localparam logic [6:0]  LEN_EXT16   = 7'd126;
    localparam logic [6:0]  LEN_EXT64   = 7'd127;
    localparam logic [3:0]  EXT16_BYTES = 4'd2;
    localparam logic [3:0]  EXT64_BYTES = 4'd8;
    localparam logic [3:0]  KEY_LAST    = 4'd3;

    localparam int QDEPTH  = 4;
    localparam int QADDR_W = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [3:0]  frame_opcode;
        logic [3:0]  frame_flags;
        logic [15:0] close_code;
        logic        last;
    } wsfd_result_t;

    typedef struct packed {
        logic         valid;
        wsfd_result_t result;
    } wsfd_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } wsfd_qstat_t;

endpackage

// File: hdl/wsfd_front.sv
// header parser and payload unmasker, one byte per cycle while the result queue is not full
module wsfd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_in_byte,
    input  wsfd_pkg::wsfd_qstat_t q_stat,
    output wsfd_pkg::wsfd_push_t  push
);
    import wsfd_pkg::*;

    wsfd_phase_t phase_reg, phase_next;
    logic [3:0]  flags_reg, flags_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [63:0] len_reg, len_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  lane_reg, lane_next;
    logic [1:0]  pos_reg, pos_next;
    logic [15:0] code_reg, code_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic [7:0]  key_byte;
    logic [7:0]  data;
    logic        is_last;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        unique case (lane_reg)
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign data    = s_in_byte ^ key_byte;
    assign is_last = (len_reg == 64'd1);

    always_comb begin
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        opcode_next  = opcode_reg;
        len_next     = len_reg;
        hdr_cnt_next = hdr_cnt_reg;
        key_next     = key_reg;
        lane_next    = lane_reg;
        pos_next     = pos_reg;
        code_next    = code_reg;
        halted_next  = halted_reg;
        push.valid               = 1'b0;
        push.result.kind         = KIND_MSG;
        push.result.payload_byte = 8'd0;
        push.result.frame_opcode = opcode_reg;
        push.result.frame_flags  = flags_reg;
        push.result.close_code   = 16'd0;
        push.result.last         = 1'b1;
        if (accept && !halted_reg) begin
            unique case (phase_reg)
                PH_HDR0: begin
                    flags_next  = s_in_byte[7:4];
                    opcode_next = s_in_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1: begin
                    if (!s_in_byte[7]) begin
                        halted_next      = 1'b1;
                        phase_next       = PH_HDR0;
                        push.valid       = 1'b1;
                        push.result.kind = KIND_ERROR;
                    end else begin
                        key_next     = 32'd0;
                        hdr_cnt_next = 4'd0;
                        if (s_in_byte[6:0] == LEN_EXT16) begin
                            len_next     = 64'd0;
                            hdr_cnt_next = EXT16_BYTES;
                            phase_next   = PH_EXT;
                        end else if (s_in_byte[6:0] == LEN_EXT64) begin
                            len_next     = 64'd0;
                            hdr_cnt_next = EXT64_BYTES;
                            phase_next   = PH_EXT;
                        end else begin
                            len_next   = {57'd0, s_in_byte[6:0]};
                            phase_next = PH_KEY;
                        end
                    end
                end
                PH_EXT: begin
                    len_next     = {len_reg[55:0], s_in_byte};
                    hdr_cnt_next = hdr_cnt_reg - 4'd1;
                    if (hdr_cnt_reg == 4'd1) begin
                        phase_next = PH_KEY;
                    end
                end
                PH_KEY: begin
                    key_next     = {key_reg[23:0], s_in_byte};
                    hdr_cnt_next = hdr_cnt_reg + 4'd1;
                    if (hdr_cnt_reg == KEY_LAST) begin
                        hdr_cnt_next = 4'd0;
                        lane_next    = 2'd0;
                        pos_next     = 2'd0;
                        code_next    = CODE_NORMAL;
                        if (len_reg != 64'd0) begin
                            phase_next = PH_DATA;
                        end else begin
                            phase_next = PH_HDR0;
                            push.valid = 1'b1;
                            if (opcode_reg == OPC_CLOSE) begin
                                push.result.kind       = KIND_CLOSE;
                                push.result.close_code = CODE_NORMAL;
                            end else begin
                                push.result.kind = KIND_EMPTY;
                            end
                        end
                    end
                end
                default: begin
                    len_next  = len_reg - 64'd1;
                    lane_next = lane_reg + 2'd1;
                    if (pos_reg != 2'd2) begin
                        pos_next = pos_reg + 2'd1;
                    end
                    if (is_last) begin
                        phase_next = PH_HDR0;
                    end
                    if (opcode_reg != OPC_CLOSE) begin
                        push.valid               = 1'b1;
                        push.result.kind         = KIND_MSG;
                        push.result.payload_byte = data;
                        push.result.last         = is_last;
                    end else if (pos_reg == 2'd0) begin
                        if (is_last) begin
                            push.valid             = 1'b1;
                            push.result.kind       = KIND_CLOSE;
                            push.result.close_code = CODE_NORMAL;
                        end else begin
                            code_next = {data, 8'd0};
                        end
                    end else if (pos_reg == 2'd1) begin
                        code_next = {code_reg[15:8], data};
                        if (is_last) begin
                            push.valid             = 1'b1;
                            push.result.kind       = KIND_CLOSE;
                            push.result.close_code = {code_reg[15:8], data};
                        end
                    end else begin
                        push.valid               = 1'b1;
                        push.result.kind         = KIND_REASON;
                        push.result.payload_byte = data;
                        push.result.close_code   = code_reg;
                        push.result.last         = is_last;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            flags_reg   <= 4'd0;
            opcode_reg  <= 4'd0;
            len_reg     <= 64'd0;
            hdr_cnt_reg <= 4'd0;
            key_reg     <= 32'd0;
            lane_reg    <= 2'd0;
            pos_reg     <= 2'd0;
            code_reg    <= 16'd0;
            halted_reg  <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            flags_reg   <= flags_next;
            opcode_reg  <= opcode_next;
            len_reg     <= len_next;
            hdr_cnt_reg <= hdr_cnt_next;
            key_reg     <= key_next;
            lane_reg    <= lane_next;
            pos_reg     <= pos_next;
            code_reg    <= code_next;
            halted_reg  <= halted_next;
        end
    end

endmodule

// File: hdl/wsfd_queue.sv
// short result queue between parser and output stage
module wsfd_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wsfd_pkg::wsfd_push_t   push,
    input  logic                   pop,
    output wsfd_pkg::wsfd_result_t head,
    output wsfd_pkg::wsfd_qstat_t  stat
);
    import wsfd_pkg::*;

    wsfd_result_t        entry_reg [QDEPTH];
    logic [QADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = wr_ptr_reg + QADDR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QADDR_W'(1);
        end
        if (push.valid && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push.valid) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/wsfd_back.sv
// output register stage of the result channel
module wsfd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wsfd_pkg::wsfd_result_t head,
    input  wsfd_pkg::wsfd_qstat_t  q_stat,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_kind,
    output logic [7:0]             m_payload_byte,
    output logic [3:0]             m_frame_opcode,
    output logic [3:0]             m_frame_flags,
    output logic [15:0]            m_close_code,
    output logic                   m_last
);
    import wsfd_pkg::*;

    logic         valid_reg, valid_next;
    wsfd_result_t out_reg;

    assign pop = !q_stat.empty && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= head;
        end
    end

    assign m_valid        = valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_frame_opcode = out_reg.frame_opcode;
    assign m_frame_flags  = out_reg.frame_flags;
    assign m_close_code   = out_reg.close_code;
    assign m_last         = out_reg.last;

endmodule

// File: hdl/websocket_frame_deframer.sv
// top level of the websocket receive frame deframer
// Takes one received byte per cycle and keeps that rate indefinitely as long as the
// result channel keeps up: the parser updates its header state or unmasks one payload
// byte per accepted byte, and a four-entry result queue plus an output register lets
// the input side run on while results wait. Header, extended length and key bytes
// give no result, except the last key byte of an empty frame, which gives an empty or
// close result; an unmasked frame gives one error result and all later bytes are
// taken and dropped until reset. s_ready falls only when the result queue is full.
module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [3:0]  m_frame_opcode,
    output logic [3:0]  m_frame_flags,
    output logic [15:0] m_close_code,
    output logic        m_last
);
    import wsfd_pkg::*;

    wsfd_push_t   push;
    wsfd_qstat_t  q_stat;
    wsfd_result_t head;
    logic         pop;

    wsfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_stat    (q_stat),
        .push      (push)
    );

    wsfd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .stat    (q_stat)
    );

    wsfd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .q_stat         (q_stat),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_frame_opcode (m_frame_opcode),
        .m_frame_flags  (m_frame_flags),
        .m_close_code   (m_close_code),
        .m_last         (m_last)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !q_stat.full)
        else $error("result pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("result popped from empty queue");

    a_silent_after_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid && push.result.kind == KIND_ERROR) |=> !push.valid)
        else $error("result produced after unmasked frame error");

    a_single_results_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_EMPTY || m_kind == KIND_CLOSE
            || m_kind == KIND_ERROR)) |-> m_last)
        else $error("single result transaction without last");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// testbench of the websocket frame deframer: frame stimulus, byte-level predictor, scoreboard
module tb;
    import wsfd_pkg::*;

    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_BYTES = 300;
    localparam int LONG_FRAME   = 260;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int PRINT_LIMIT  = 40;

    typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_t;
    typedef enum int {SINK_FREE, SINK_HALF, SINK_SLOW, SINK_JITTER} sink_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_kind;
    logic [7:0]  m_payload_byte;
    logic [3:0]  m_frame_opcode;
    logic [3:0]  m_frame_flags;
    logic [15:0] m_close_code;
    logic        m_last;

    // predicted parser state
    wsfd_phase_t  rx_phase;
    logic [3:0]   rx_flags;
    logic [3:0]   rx_opcode;
    logic [63:0]  rx_length;
    logic [63:0]  rx_position;
    logic [3:0]   rx_count;
    logic [31:0]  rx_key;
    logic [15:0]  rx_code;
    logic         rx_halted;

    wsfd_result_t expected_results[$];
    logic [7:0]   frame_body[$];
    int           error_count;
    int           bytes_sent;
    int           burst_left;
    bit           stream_guard;
    bit           sink_hold;

    websocket_frame_deframer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_frame_opcode (m_frame_opcode),
        .m_frame_flags  (m_frame_flags),
        .m_close_code   (m_close_code),
        .m_last         (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void expect_result(logic [2:0] kind, logic [7:0] data,
                                          logic [15:0] code, logic last);
        wsfd_result_t r;
        r.kind         = kind;
        r.payload_byte = data;
        r.frame_opcode = rx_opcode;
        r.frame_flags  = rx_flags;
        r.close_code   = code;
        r.last         = last;
        expected_results.push_back(r);
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        logic [7:0]  d;
        logic        at_end;
        logic [63:0] pos;
        int          shift;
        if (rx_halted)
            return;
        case (rx_phase)
            PH_HDR0: begin
                rx_flags  = b[7:4];
                rx_opcode = b[3:0];
                rx_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                if (!b[7]) begin
                    rx_halted = 1'b1;
                    rx_phase  = PH_HDR0;
                    expect_result(KIND_ERROR, 8'h00, 16'h0000, 1'b1);
                end else begin
                    rx_key = '0;
                    if (b[6:0] == LEN_EXT16) begin
                        rx_length = '0;
                        rx_count  = EXT16_BYTES;
                        rx_phase  = PH_EXT;
                    end else if (b[6:0] == LEN_EXT64) begin
                        rx_length = '0;
                        rx_count  = EXT64_BYTES;
                        rx_phase  = PH_EXT;
                    end else begin
                        rx_length = {57'd0, b[6:0]};
                        rx_count  = '0;
                        rx_phase  = PH_KEY;
                    end
                end
            end
            PH_EXT: begin
                rx_length = {rx_length[55:0], b};
                rx_count  = rx_count - 4'd1;
                if (rx_count == 4'd0)
                    rx_phase = PH_KEY;
            end
            PH_KEY: begin
                rx_key = {rx_key[23:0], b};
                if (rx_count != KEY_LAST) begin
                    rx_count = rx_count + 4'd1;
                end else begin
                    rx_count    = '0;
                    rx_position = '0;
                    rx_code     = CODE_NORMAL;
                    if (rx_length != 64'd0) begin
                        rx_phase = PH_DATA;
                    end else begin
                        rx_phase = PH_HDR0;
                        if (rx_opcode == OPC_CLOSE)
                            expect_result(KIND_CLOSE, 8'h00, CODE_NORMAL, 1'b1);
                        else
                            expect_result(KIND_EMPTY, 8'h00, 16'h0000, 1'b1);
                    end
                end
            end
            default: begin
                pos         = rx_position;
                shift       = 8 * (3 - int'(pos[1:0]));
                d           = 8'(rx_key >> shift) ^ b;
                at_end      = (pos == rx_length - 64'd1);
                rx_position = pos + 64'd1;
                if (at_end)
                    rx_phase = PH_HDR0;
                if (rx_opcode != OPC_CLOSE) begin
                    expect_result(KIND_MSG, d, 16'h0000, at_end);
                end else if (pos == 64'd0) begin
                    if (rx_length == 64'd1)
                        expect_result(KIND_CLOSE, 8'h00, CODE_NORMAL, 1'b1);
                    else
                        rx_code = {d, 8'h00};
                end else if (pos == 64'd1) begin
                    rx_code = {rx_code[15:8], d};
                    if (at_end)
                        expect_result(KIND_CLOSE, 8'h00, rx_code, 1'b1);
                end else begin
                    expect_result(KIND_REASON, d, rx_code, at_end);
                end
            end
        endcase
    endfunction

    function automatic void compare_field(string field, int want, int got);
        if (want != got) begin
            if (error_count < PRINT_LIMIT)
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // one byte per call, entered and left at a falling edge
    task automatic send_byte(input logic [7:0] value);
        logic [7:0] b;
        int         gap;
        b = value;
        // keep misaligned streams from halting or locking into huge payloads
        if (stream_guard && !rx_halted) begin
            if (rx_phase == PH_HDR1)
                b[7] = 1'b1;
            if (rx_phase == PH_EXT && rx_count >= EXT16_BYTES)
                b = 8'h00;
        end
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        deframe_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    function automatic void fill_body(int n);
        frame_body.delete();
        repeat (n) frame_body.push_back(8'($urandom));
    endfunction

    // masks frame_body and sends header and payload, only the first keep bytes if keep >= 0
    task automatic send_frame(input logic [3:0] flags, input logic [3:0] opcode,
                              input len_form_t form, input logic [31:0] key,
                              input int keep);
        logic [7:0]  wire_q[$];
        logic [63:0] len;
        len = 64'(frame_body.size());
        wire_q.push_back({flags, opcode});
        case (form)
            LEN_SHORT: wire_q.push_back({1'b1, len[6:0]});
            LEN_16: begin
                wire_q.push_back({1'b1, LEN_EXT16});
                wire_q.push_back(len[15:8]);
                wire_q.push_back(len[7:0]);
            end
            default: begin
                wire_q.push_back({1'b1, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    wire_q.push_back(len[8 * i +: 8]);
            end
        endcase
        for (int i = 3; i >= 0; i--)
            wire_q.push_back(key[8 * i +: 8]);
        foreach (frame_body[i])
            wire_q.push_back(frame_body[i] ^ key[8 * (3 - i % 4) +: 8]);
        if (keep < 0 || keep > wire_q.size())
            keep = wire_q.size();
        for (int i = 0; i < keep; i++)
            send_byte(wire_q[i]);
    endtask

    task automatic send_random_frame(input int keep);
        logic [3:0] opcode;
        len_form_t  form;
        int         n;
        int         pick;
        opcode = ($urandom_range(0, 9) < 3) ? OPC_CLOSE : 4'($urandom);
        pick   = $urandom_range(0, 99);
        if (pick < 12)
            n = 0;
        else if (pick < 25)
            n = $urandom_range(1, 2);
        else if (pick < 85)
            n = $urandom_range(3, 16);
        else if (pick < 97)
            n = $urandom_range(17, 125);
        else
            n = $urandom_range(126, 300);
        if (n > 125 || $urandom_range(0, 4) == 0)
            form = len_form_t'($urandom_range(1, 2));
        else
            form = LEN_SHORT;
        fill_body(n);
        send_frame(4'($urandom), opcode, form, $urandom, keep);
    endtask

    task automatic test_empty_frames();
        frame_body.delete();
        send_frame(4'hF, 4'hF, LEN_SHORT, 32'hFFFF_FFFF, -1);
        send_frame(4'h8, OPC_CLOSE, LEN_SHORT, 32'h0000_0000, -1);
    endtask

    task automatic test_short_close();
        frame_body = '{8'hA5};
        send_frame(4'h8, OPC_CLOSE, LEN_SHORT, 32'h1234_5678, -1);
        frame_body = '{8'hFF, 8'hFF};
        send_frame(4'h0, OPC_CLOSE, LEN_SHORT, 32'hC3A5_5A3C, -1);
    endtask

    task automatic test_backpressure();
        sink_hold = 1'b1;
        fill_body(60);
        send_frame(4'h8, 4'h1, LEN_SHORT, $urandom, -1);
    endtask

    task automatic test_long_frame();
        fill_body(LONG_FRAME);
        send_frame(4'h8, 4'h2, LEN_64, $urandom, -1);
    endtask

    task automatic test_random_frames();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
            send_random_frame(-1);
    endtask

    task automatic test_broken_streams();
        stream_guard = 1'b1;
        repeat (8) begin
            if ($urandom_range(0, 1) == 1)
                send_random_frame(-1);
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
            else
                send_random_frame($urandom_range(1, 12));
            while (rx_phase != PH_HDR0)
                send_byte(8'($urandom));
        end
        stream_guard = 1'b0;
    endtask

    task automatic test_unmasked_halt();
        send_byte({4'h9, 4'h2});
        send_byte({1'b0, LEN_EXT64});
        repeat (16) send_byte(8'($urandom));
    endtask

    // result channel stall pattern, with one long hold-off on request
    initial begin : result_sink
        sink_mode_t mode;
        int         mode_left;
        mode      = SINK_FREE;
        mode_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                sink_hold = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 96);
                end
                mode_left--;
                case (mode)
                    SINK_FREE: m_ready <= 1'b1;
                    SINK_HALF: m_ready <= ($urandom_range(0, 1) == 1);
                    SINK_SLOW: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_check
        wsfd_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                if (error_count < PRINT_LIMIT)
                    $display("%0t: result expected none actual kind %0d byte %0d",
                             $time, m_kind, m_payload_byte);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("kind", want.kind, m_kind);
                compare_field("payload_byte", want.payload_byte, m_payload_byte);
                compare_field("frame_opcode", want.frame_opcode, m_frame_opcode);
                compare_field("frame_flags", want.frame_flags, m_frame_flags);
                compare_field("close_code", want.close_code, m_close_code);
                compare_field("last", want.last, m_last);
            end
        end
    end

    initial begin
        s_valid      = 1'b0;
        s_in_byte    = 8'h00;
        aresetn      = 1'b0;
        rx_phase     = PH_HDR0;
        rx_flags     = '0;
        rx_opcode    = '0;
        rx_length    = '0;
        rx_position  = '0;
        rx_count     = '0;
        rx_key       = '0;
        rx_code      = '0;
        rx_halted    = 1'b0;
        error_count  = 0;
        bytes_sent   = 0;
        burst_left   = 0;
        stream_guard = 1'b0;
        sink_hold    = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_frames();
        test_short_close();
        test_backpressure();
        test_long_frame();
        test_random_frames();
        test_broken_streams();
        test_unmasked_halt();

        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
hdl/wsfd_pkg.sv
hdl/wsfd_front.sv
hdl/wsfd_queue.sv
hdl/wsfd_back.sv
hdl/websocket_frame_deframer.sv
tb/tb.sv
